// ===== src/css_pkg.sv =====
// css_pkg: shared types and constants for the comment span scanner
// no dependencies

package css_pkg;

   typedef enum logic [3:0] {
      MD_NORMAL, MD_DQ1, MD_DQ2, MD_SQ1, MD_SQ2, MD_DSTR, MD_DESC,
      MD_SSTR, MD_SESC, MD_DDOC, MD_SDOC, MD_LINE
   } mode_type;

   localparam int NUM_KW = 12;
   localparam int KW_MAX = 10;

   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_BSL   = 8'h5c;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_SQ    = 8'h27;
   localparam logic [7:0] CH_NL    = 8'h0a;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;

   localparam logic [1:0] ATT_LEADING  = 2'd0;
   localparam logic [1:0] ATT_TRAILING = 2'd1;
   localparam logic [1:0] ATT_FLOATING = 2'd2;

   localparam logic KIND_LINE = 1'b0;
   localparam logic KIND_DOC  = 1'b1;

   // keyword lengths, each including its trailing space
   function automatic logic [3:0] kw_len(input int k);
      logic [3:0] r;
      unique case (k)
         0: r = 4'd7;  1: r = 4'd8;  2: r = 4'd8;  3: r = 4'd9;
         4: r = 4'd6;  5: r = 4'd10; 6: r = 4'd7;  7: r = 4'd5;
         8: r = 4'd7;  9: r = 4'd6;  10: r = 4'd9; default: r = 4'd6;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] kw_char(input int k, input logic [3:0] i);
      logic [79:0] s;
      unique case (k)
         0: s = {"public ", 24'h0};
         1: s = {"protect ", 16'h0};
         2: s = {"private ", 16'h0};
         3: s = {"function ", 8'h0};
         4: s = {"class ", 32'h0};
         5: s = "interface ";
         6: s = {"struct ", 24'h0};
         7: s = {"enum ", 40'h0};
         8: s = {"extern ", 24'h0};
         9: s = {"const ", 32'h0};
         10: s = {"property ", 8'h0};
         default: s = {"async ", 32'h0};
      endcase
      if (i >= 4'd10) return 8'h00;
      return s[79 - 8*int'(i) -: 8];
   endfunction

endpackage

// ===== src/css_lookahead.sv =====
// css_lookahead: keyword match of the text after a held line comment
// depends on css_pkg

module css_lookahead (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,      // transaction taken
   input  logic                      active,    // held comment valid
   input  logic                      restart,   // new comment held
   input  logic [7:0]                text_byte,
   output logic                      hit,
   output logic                      miss
);

   logic [css_pkg::NUM_KW-1:0] cand_ff, cand_in, cand_nx;
   logic [3:0]                 off_ff, off_in;
   logic                       skip;

   always_comb begin
      skip = (off_ff == 4'd0) && (text_byte == css_pkg::CH_SP ||
             text_byte == css_pkg::CH_TAB || text_byte == css_pkg::CH_NL);
      cand_nx = cand_ff;
      hit = 1'b0;
      for (int k = 0; k < css_pkg::NUM_KW; k++) begin
         if (cand_ff[k]) begin
            if (off_ff >= css_pkg::kw_len(k) ||
                css_pkg::kw_char(k, off_ff) != text_byte) begin
               cand_nx[k] = 1'b0;
            end else if (off_ff + 4'd1 == css_pkg::kw_len(k)) begin
               hit = 1'b1;
            end
         end
      end
      hit  = active && !skip && hit;
      miss = active && !skip && !hit && (cand_nx == '0);
   end

   always_comb begin
      cand_in = cand_ff;
      off_in  = off_ff;
      if (restart) begin
         cand_in = '1;
         off_in  = 4'd0;
      end else if (active && !skip && !hit && !miss) begin
         cand_in = cand_nx;
         off_in  = off_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff <= '1;
         off_ff  <= 4'd0;
      end else if (step) begin
         cand_ff <= cand_in;
         off_ff  <= off_in;
      end
   end

endmodule

// ===== src/comment_span_scanner.sv =====
// comment_span_scanner: top level, byte scanner with line/column tracking
// depends on css_pkg and css_lookahead
//
//  channel | dir | tdata fields (low bit first)                       | side band
//  req     | in  | text_byte[7:0]                                     | tlast = is_final
//  rsp     | out | first_line, first_column, final_line, final_column, | tuser = comment_kind
//          |     | attachment, zero fill to bytes                     |
//
// one byte per cycle unless the output register is full and stalled; the scanner state updates in the accepting cycle
// a result stands in one output register, valid the cycle after the deciding byte
// a byte is taken while that register is empty or being taken at the same edge
// synchronous reset returns to line 1, column 1, normal code

module comment_span_scanner #(
   parameter int LINE_BITS   = 20,
   parameter int COLUMN_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,   // text_byte
   input  logic req_tlast,         // is_final
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // first_line, first_column, final_line, final_column, attachment
   output logic [((2*LINE_BITS + 2*COLUMN_BITS + 2 + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic rsp_tuser          // comment_kind
);

   localparam int PW = 2*LINE_BITS + 2*COLUMN_BITS + 2;
   localparam int RW = ((PW + 7) / 8) * 8;
   localparam logic [LINE_BITS-1:0]   LMAX = '1;
   localparam logic [COLUMN_BITS-1:0] CMAX = '1;

   css_pkg::mode_type mode_ff, mode_in;
   logic [LINE_BITS-1:0]   line_ff, line_in, osl_ff, osl_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in, osc_ff, osc_in;
   logic [1:0] qrun_ff, qrun_in;
   logic code_ff, code_in, ocode_ff, ocode_in;
   logic hv_ff, hv_in, hcb_ff, hcb_in;
   logic [LINE_BITS-1:0]   hl_ff, hl_in;
   logic [COLUMN_BITS-1:0] hc0_ff, hc0_in, hc1_ff, hc1_in;
   logic ov_ff, ov_in;
   logic [RW-1:0] od_ff, od_in;
   logic kind_ff, kind_in;

   logic take, hit, miss, restart, em, nb;
   logic [7:0] b;
   logic ekind;
   logic [LINE_BITS-1:0] el0, el1;
   logic [COLUMN_BITS-1:0] ec0, ec1;
   logic [1:0] eatt;

   assign b          = req_tdata;
   assign req_tready = !ov_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tuser  = kind_ff;

   css_lookahead u_look (
      .clock(clock), .reset(reset), .step(take),
      .active(hv_ff), .restart(restart || req_tlast),
      .text_byte(b), .hit(hit), .miss(miss)
   );

   always_comb begin
      mode_in = mode_ff; osl_in = osl_ff; osc_in = osc_ff; qrun_in = qrun_ff;
      ocode_in = ocode_ff; hv_in = hv_ff; hcb_in = hcb_ff; hl_in = hl_ff;
      hc0_in = hc0_ff; hc1_in = hc1_ff; restart = 1'b0; em = 1'b0;
      ekind = css_pkg::KIND_LINE; el0 = hl_ff; ec0 = hc0_ff; el1 = hl_ff;
      ec1 = hc1_ff; eatt = css_pkg::ATT_LEADING; nb = 1'b0;
      line_in = line_ff; col_in = col_ff;
      if (b == css_pkg::CH_NL) begin
         if (line_ff < LMAX) line_in = line_ff + 1'b1;
         col_in = COLUMN_BITS'(1);
      end else if (col_ff < CMAX) begin
         col_in = col_ff + 1'b1;
      end
      if (hit || miss) begin
         em = 1'b1; hv_in = 1'b0;
         eatt = hit ? css_pkg::ATT_LEADING
              : (hcb_ff ? css_pkg::ATT_TRAILING : css_pkg::ATT_FLOATING);
      end
      unique case (mode_ff)
         css_pkg::MD_NORMAL: nb = 1'b1;
         css_pkg::MD_DQ1: mode_in = (b == css_pkg::CH_DQ) ? css_pkg::MD_DQ2
              : (b == css_pkg::CH_BSL) ? css_pkg::MD_DESC : css_pkg::MD_DSTR;
         css_pkg::MD_SQ1: mode_in = (b == css_pkg::CH_SQ) ? css_pkg::MD_SQ2
              : (b == css_pkg::CH_BSL) ? css_pkg::MD_SESC : css_pkg::MD_SSTR;
         css_pkg::MD_DQ2, css_pkg::MD_SQ2: begin
            if (b == ((mode_ff == css_pkg::MD_DQ2) ? css_pkg::CH_DQ
                                                     : css_pkg::CH_SQ)) begin
               mode_in = (mode_ff == css_pkg::MD_DQ2) ? css_pkg::MD_DDOC
                                                       : css_pkg::MD_SDOC;
               qrun_in = 2'd0;
            end else begin
               mode_in = css_pkg::MD_NORMAL; nb = 1'b1;
            end
         end
         css_pkg::MD_DSTR: if (b == css_pkg::CH_DQ) mode_in = css_pkg::MD_NORMAL;
            else if (b == css_pkg::CH_BSL) mode_in = css_pkg::MD_DESC;
         css_pkg::MD_SSTR: if (b == css_pkg::CH_SQ) mode_in = css_pkg::MD_NORMAL;
            else if (b == css_pkg::CH_BSL) mode_in = css_pkg::MD_SESC;
         css_pkg::MD_DESC: mode_in = css_pkg::MD_DSTR;
         css_pkg::MD_SESC: mode_in = css_pkg::MD_SSTR;
         css_pkg::MD_DDOC, css_pkg::MD_SDOC: begin
            if (b == ((mode_ff == css_pkg::MD_DDOC) ? css_pkg::CH_DQ
                                                      : css_pkg::CH_SQ)) begin
               if (qrun_ff == 2'd2) begin
                  qrun_in = 2'd0; mode_in = css_pkg::MD_NORMAL;
                  if (!em) begin
                     em = 1'b1; ekind = css_pkg::KIND_DOC; el0 = osl_ff;
                     ec0 = osc_ff; el1 = line_in; ec1 = col_in;
                     eatt = css_pkg::ATT_LEADING;
                  end
               end else begin
                  qrun_in = qrun_ff + 2'd1;
               end
            end else begin
               qrun_in = 2'd0;
            end
         end
         css_pkg::MD_LINE: if (b == css_pkg::CH_NL) begin
            hv_in = 1'b1; hcb_in = ocode_ff; hl_in = osl_ff; hc0_in = osc_ff;
            hc1_in = col_ff; restart = 1'b1; mode_in = css_pkg::MD_NORMAL;
         end
         default: mode_in = css_pkg::MD_NORMAL;
      endcase
      if (nb) begin
         if (b == css_pkg::CH_HASH) begin
            mode_in = css_pkg::MD_LINE; ocode_in = code_ff;
         end else if (b == css_pkg::CH_DQ) begin
            mode_in = css_pkg::MD_DQ1;
         end else if (b == css_pkg::CH_SQ) begin
            mode_in = css_pkg::MD_SQ1;
         end
         if (b == css_pkg::CH_HASH || b == css_pkg::CH_DQ || b == css_pkg::CH_SQ) begin
            osl_in = line_ff; osc_in = col_ff;
         end
      end
      if (b == css_pkg::CH_NL) code_in = 1'b0;
      else if (b != css_pkg::CH_SP && b != css_pkg::CH_TAB) code_in = 1'b1;
      else code_in = code_ff;
      if (req_tlast) begin
         if (hv_in && !em) begin
            em = 1'b1; ekind = css_pkg::KIND_LINE; el0 = hl_in; ec0 = hc0_in;
            el1 = hl_in; ec1 = hc1_in;
            eatt = hcb_in ? css_pkg::ATT_TRAILING : css_pkg::ATT_FLOATING;
         end else if (mode_in == css_pkg::MD_LINE && !em) begin
            em = 1'b1; ekind = css_pkg::KIND_LINE; el0 = osl_in; ec0 = osc_in;
            el1 = osl_in; ec1 = col_in;
            eatt = ocode_in ? css_pkg::ATT_TRAILING : css_pkg::ATT_FLOATING;
         end else if ((mode_in == css_pkg::MD_DDOC || mode_in == css_pkg::MD_SDOC)
                      && !em) begin
            em = 1'b1; ekind = css_pkg::KIND_DOC; el0 = osl_in; ec0 = osc_in;
            el1 = line_in; ec1 = col_in; eatt = css_pkg::ATT_LEADING;
         end
         mode_in = css_pkg::MD_NORMAL; line_in = LINE_BITS'(1);
         col_in = COLUMN_BITS'(1); osl_in = '0; osc_in = '0; qrun_in = 2'd0;
         code_in = 1'b0; ocode_in = 1'b0; hv_in = 1'b0;
      end
      od_in   = RW'({eatt, ec1, el1, ec0, el0});
      kind_in = ekind;
      ov_in = ov_ff && !rsp_tready;
      if (take && em) ov_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= css_pkg::MD_NORMAL; line_ff <= LINE_BITS'(1);
         col_ff <= COLUMN_BITS'(1); osl_ff <= '0; osc_ff <= '0;
         qrun_ff <= 2'd0; code_ff <= 1'b0; ocode_ff <= 1'b0;
         hv_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         ov_ff <= ov_in;
         if (take) begin
            mode_ff <= mode_in; line_ff <= line_in; col_ff <= col_in;
            osl_ff <= osl_in; osc_ff <= osc_in; qrun_ff <= qrun_in;
            code_ff <= code_in; ocode_ff <= ocode_in; hv_ff <= hv_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         hcb_ff <= hcb_in; hl_ff <= hl_in; hc0_ff <= hc0_in; hc1_ff <= hc1_in;
      end
      if (take && em) begin
         od_ff <= od_in; kind_ff <= kind_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result lost while stalled");
   a_last_resets: assert property (@(posedge clock) disable iff (reset)
      take && req_tlast |=> line_ff == LINE_BITS'(1) && !hv_ff)
      else $error("end of text did not restart scan");
   a_hit_miss: assert property (@(posedge clock) disable iff (reset)
      !(hit && miss))
      else $error("lookahead both hit and miss");
   a_held_emit: assert property (@(posedge clock) disable iff (reset)
      take && hv_ff && (hit || miss) |=> rsp_tvalid)
      else $error("decided comment not emitted");
`endif

endmodule

// ===== tb/sv/comment_span_scanner_test.sv =====
`timescale 1ns / 100ps
// comment_span_scanner_test: self-checking bench for the comment span scanner
// depends on css_pkg and comment_span_scanner; predicts every comment span and compares
// each rsp transaction with the oldest expected span

module comment_span_scanner_test;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [19:0] LINE_TOP = 20'hFFFFF;
   localparam logic [15:0] COL_TOP  = 16'hFFFF;

   typedef struct {
      logic        kind;
      logic [19:0] l0;
      logic [15:0] c0;
      logic [19:0] l1;
      logic [15:0] c1;
      logic [1:0]  att;
   } span_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = 8'h00;   // text_byte
   logic req_tlast = 1'b0;          // is_final
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // first_line, first_column, final_line, final_column, attachment
   logic [79:0] rsp_tdata;
   logic rsp_tuser;                 // comment_kind

   span_type span_queue[$];
   int    errors = 0;
   int    idle_cycles = 0;
   int    hold_cycles = 0;
   int    sent_items = 0;
   bit    no_gaps = 1'b0;

   // scanner shadow state
   css_pkg::mode_type sc_mode;
   logic [19:0] sc_line, sc_open_line;
   logic [15:0] sc_col, sc_open_col;
   int          sc_quotes;
   bit          sc_code, sc_open_code;
   bit          hd_valid, hd_code;
   logic [19:0] hd_l0, hd_l1;
   logic [15:0] hd_c0, hd_c1;
   logic [11:0] kw_alive;
   int          kw_pos;
   bit          step_emitted;
   string       kw_words[12] = '{"public ", "protect ", "private ", "function ", "class ",
                                 "interface ", "struct ", "enum ", "extern ", "const ",
                                 "property ", "async "};

   comment_span_scanner dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   task automatic scanner_clear();
      sc_mode = css_pkg::MD_NORMAL;
      sc_line = 20'd1;
      sc_col = 16'd1;
      sc_open_line = '0;
      sc_open_col = '0;
      sc_quotes = 0;
      sc_code = 1'b0;
      sc_open_code = 1'b0;
      hd_valid = 1'b0;
      hd_code = 1'b0;
      kw_alive = '1;
      kw_pos = 0;
   endtask

   task automatic push_span(logic kind, logic [19:0] l0, logic [15:0] c0,
                            logic [19:0] l1, logic [15:0] c1, logic [1:0] att);
      span_type s;
      if (!step_emitted) begin
         s.kind = kind; s.l0 = l0; s.c0 = c0; s.l1 = l1; s.c1 = c1; s.att = att;
         span_queue.insert(span_queue.size(), s);
         step_emitted = 1'b1;
      end
   endtask

   task automatic decide_held(bit leading);
      push_span(css_pkg::KIND_LINE, hd_l0, hd_c0, hd_l1, hd_c1,
                leading ? css_pkg::ATT_LEADING
                        : (hd_code ? css_pkg::ATT_TRAILING : css_pkg::ATT_FLOATING));
      hd_valid = 1'b0;
   endtask

   task automatic keyword_lookahead(logic [7:0] b);
      if (kw_pos == 0 && (b == css_pkg::CH_SP || b == css_pkg::CH_TAB ||
                          b == css_pkg::CH_NL)) return;
      for (int k = 0; k < 12; k++) begin
         if (kw_alive[k]) begin
            if (kw_pos >= kw_words[k].len() || kw_words[k][kw_pos] != b) begin
               kw_alive[k] = 1'b0;
            end else if (kw_pos + 1 == kw_words[k].len()) begin
               decide_held(1'b1);
               return;
            end
         end
      end
      if (kw_alive == '0) begin
         decide_held(1'b0);
         return;
      end
      kw_pos++;
   endtask

   task automatic code_byte(logic [7:0] b);
      if (b == css_pkg::CH_HASH) begin
         sc_mode = css_pkg::MD_LINE;
         sc_open_code = sc_code;
      end else if (b == css_pkg::CH_DQ) begin
         sc_mode = css_pkg::MD_DQ1;
      end else if (b == css_pkg::CH_SQ) begin
         sc_mode = css_pkg::MD_SQ1;
      end else begin
         return;
      end
      sc_open_line = sc_line;
      sc_open_col = sc_col;
   endtask

   task automatic predict_spans(logic [7:0] b, bit fin);
      logic [19:0] nl;
      logic [15:0] nc;
      bit dq;
      nl = sc_line;
      nc = sc_col;
      step_emitted = 1'b0;
      if (b == css_pkg::CH_NL) begin
         if (nl < LINE_TOP) nl++;
         nc = 16'd1;
      end else if (nc < COL_TOP) begin
         nc++;
      end
      if (hd_valid) keyword_lookahead(b);
      unique case (sc_mode)
         css_pkg::MD_NORMAL: code_byte(b);
         css_pkg::MD_DQ1, css_pkg::MD_SQ1: begin
            dq = (sc_mode == css_pkg::MD_DQ1);
            if (b == (dq ? css_pkg::CH_DQ : css_pkg::CH_SQ))
               sc_mode = dq ? css_pkg::MD_DQ2 : css_pkg::MD_SQ2;
            else if (b == css_pkg::CH_BSL) sc_mode = dq ? css_pkg::MD_DESC : css_pkg::MD_SESC;
            else sc_mode = dq ? css_pkg::MD_DSTR : css_pkg::MD_SSTR;
         end
         css_pkg::MD_DQ2, css_pkg::MD_SQ2: begin
            dq = (sc_mode == css_pkg::MD_DQ2);
            if (b == (dq ? css_pkg::CH_DQ : css_pkg::CH_SQ)) begin
               sc_mode = dq ? css_pkg::MD_DDOC : css_pkg::MD_SDOC;
               sc_quotes = 0;
            end else begin
               sc_mode = css_pkg::MD_NORMAL;
               code_byte(b);
            end
         end
         css_pkg::MD_DSTR: begin
            if (b == css_pkg::CH_DQ) sc_mode = css_pkg::MD_NORMAL;
            else if (b == css_pkg::CH_BSL) sc_mode = css_pkg::MD_DESC;
         end
         css_pkg::MD_SSTR: begin
            if (b == css_pkg::CH_SQ) sc_mode = css_pkg::MD_NORMAL;
            else if (b == css_pkg::CH_BSL) sc_mode = css_pkg::MD_SESC;
         end
         css_pkg::MD_DESC: sc_mode = css_pkg::MD_DSTR;
         css_pkg::MD_SESC: sc_mode = css_pkg::MD_SSTR;
         css_pkg::MD_DDOC, css_pkg::MD_SDOC: begin
            if (b == ((sc_mode == css_pkg::MD_DDOC) ? css_pkg::CH_DQ : css_pkg::CH_SQ)) begin
               sc_quotes++;
               if (sc_quotes >= 3) begin
                  push_span(css_pkg::KIND_DOC, sc_open_line, sc_open_col, nl, nc,
                            css_pkg::ATT_LEADING);
                  sc_mode = css_pkg::MD_NORMAL;
                  sc_quotes = 0;
               end
            end else begin
               sc_quotes = 0;
            end
         end
         css_pkg::MD_LINE: begin
            if (b == css_pkg::CH_NL) begin
               hd_valid = 1'b1;
               hd_code = sc_open_code;
               hd_l0 = sc_open_line;
               hd_c0 = sc_open_col;
               hd_l1 = sc_open_line;
               hd_c1 = sc_col;
               kw_alive = '1;
               kw_pos = 0;
               sc_mode = css_pkg::MD_NORMAL;
            end
         end
         default: sc_mode = css_pkg::MD_NORMAL;
      endcase
      if (b == css_pkg::CH_NL) sc_code = 1'b0;
      else if (b != css_pkg::CH_SP && b != css_pkg::CH_TAB) sc_code = 1'b1;
      sc_line = nl;
      sc_col = nc;
      if (fin) begin
         if (hd_valid) decide_held(1'b0);
         if (sc_mode == css_pkg::MD_LINE)
            push_span(css_pkg::KIND_LINE, sc_open_line, sc_open_col, sc_open_line, nc,
                      sc_open_code ? css_pkg::ATT_TRAILING : css_pkg::ATT_FLOATING);
         else if (sc_mode == css_pkg::MD_DDOC || sc_mode == css_pkg::MD_SDOC)
            push_span(css_pkg::KIND_DOC, sc_open_line, sc_open_col, nl, nc,
                      css_pkg::ATT_LEADING);
         scanner_clear();
      end
   endtask

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_byte(logic [7:0] b, bit fin);
      int gap;
      gap = no_gaps ? 0 : gap_length();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= fin;
      do @(posedge clock); while (!req_tready);
      predict_spans(b, fin);
      sent_items++;
   endtask

   task automatic send_text(string s, bit fin);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], fin && (i == s.len() - 1));
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (span_queue.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   // receiver side: random back-pressure (always ready during gap-free runs), with an optional long hold-off
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else if (reset) begin
         rsp_tready <= 1'b0;
      end else if (no_gaps) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) < 70) ||
                       ($urandom_range(0, 99) < 50 && !rsp_tready);
      end
   end

   always @(posedge clock) begin
      span_type e;
      if (rsp_tvalid && rsp_tready) begin
         if (span_queue.size() == 0) begin
            $display("%0t: unexpected span, actual %h kind %0d", $time, rsp_tdata[73:0],
                     rsp_tuser);
            errors++;
         end else begin
            e = span_queue.pop_front();
            if (rsp_tuser !== e.kind) begin
               $display("%0t: kind expected %0d actual %0d", $time, e.kind, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[19:0] !== e.l0) begin
               $display("%0t: first_line expected %0d actual %0d", $time, e.l0,
                        rsp_tdata[19:0]);
               errors++;
            end
            if (rsp_tdata[35:20] !== e.c0) begin
               $display("%0t: first_column expected %0d actual %0d", $time, e.c0,
                        rsp_tdata[35:20]);
               errors++;
            end
            if (rsp_tdata[55:36] !== e.l1) begin
               $display("%0t: final_line expected %0d actual %0d", $time, e.l1,
                        rsp_tdata[55:36]);
               errors++;
            end
            if (rsp_tdata[71:56] !== e.c1) begin
               $display("%0t: final_column expected %0d actual %0d", $time, e.c1,
                        rsp_tdata[71:56]);
               errors++;
            end
            if (rsp_tdata[73:72] !== e.att) begin
               $display("%0t: attachment expected %0d actual %0d", $time, e.att,
                        rsp_tdata[73:72]);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic test_directed();
      send_text("public x\n", 1'b0);
      send_text("a = 1 # trailing\nclass Foo\n", 1'b0);
      send_text("# floating\n\n  \tfunction f\n", 1'b0);
      send_text("# x\nfoo\n", 1'b0);
      send_text("s = \"a\\\"#b\" 'c\\'#' x\n", 1'b0);
      send_text("\"\"\"doc\n'''in\"\"\"\n", 1'b0);
      send_text("'''d\"\"\"q'''\"\"x#y\n''#z\n", 1'b0);
      send_text("#a\nenum e\n#b\n\t enumx\n", 1'b1);
      send_text("x #open", 1'b1);
      send_text("\"\"\"unclosed\n", 1'b1);
      send_text("#a\n#", 1'b1);
      send_text("\"str #", 1'b1);
      send_text("#", 1'b1);
      send_byte(8'hff, 1'b0);
      send_byte(8'h00, 1'b1);
      drain();
   endtask

   task automatic send_fragment();
      string frag;
      int r;
      r = $urandom_range(0, 15);
      case (r)
         0, 1: frag = {kw_words[$urandom_range(0, 11)], "name\n"};
         2, 3: frag = "# note\n";
         4: frag = "x = y # tail\n";
         5: frag = "  \t";
         6: frag = "\n";
         7: frag = "\"s\\\"q#\" ";
         8: frag = "'t\\'#' ";
         9: frag = "\"\"\"doc '' \"\" \n text\"\"\"";
         10: frag = "'''doc\n\"\"\"'''";
         11: frag = "\"\"";
         12: frag = "code();\n";
         13: frag = {kw_words[$urandom_range(0, 11)].substr(0, $urandom_range(0, 4)), "z "};
         default: frag = "";
      endcase
      if (frag.len() == 0) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      else send_text(frag, $urandom_range(0, 29) == 0);
   endtask

   task automatic test_back_to_back();
      no_gaps = 1'b1;
      for (int i = 0; i < 20; i++) send_fragment();
      no_gaps = 1'b0;
      drain();
   endtask

   task automatic test_random_text();
      while (sent_items < 1150) send_fragment();
      drain();
   endtask

   task automatic test_output_stall();
      hold_cycles = 400;
      for (int i = 0; i < 15; i++) send_text("# a\nb\n", 1'b0);
      drain();
   endtask

   initial begin
      scanner_clear();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_output_stall();
      test_back_to_back();
      test_random_text();
      drain();
      repeat (20) @(posedge clock);
      if (errors == 0 && span_queue.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
